// ----- rtl/iis_pkg.sv -----
package iis_pkg;

   localparam int unsigned PIXEL_W      = 8;
   localparam int unsigned PIXEL_SQ_W   = 2 * PIXEL_W;
   localparam int unsigned ROW_SUM_W    = 18;
   localparam int unsigned ROW_SQ_W     = 27;
   localparam int unsigned LINE_SUM_W   = 29;
   localparam int unsigned LINE_SQ_W    = 37;
   localparam int unsigned OUT_SUM_W    = 28;
   localparam int unsigned OUT_SQ_W     = 36;
   localparam int unsigned RSP_DATA_W   = 64;
   localparam int unsigned CFG_W        = 11;
   localparam int unsigned CSR_INDEX_W  = 8;

   localparam int unsigned MAX_WIDTH_DEFAULT  = 1024;
   localparam int unsigned MAX_HEIGHT_DEFAULT = 1024;

   localparam logic [CFG_W-1:0] CFG_DIM_RESET = 11'd1024;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

   typedef struct packed {
      logic [LINE_SQ_W-1:0]  sq_sum;
      logic [LINE_SUM_W-1:0] sum;
   } line_entry_type;

endpackage

// ----- rtl/integral_image_sum_and_square.sv -----
// Integral image and integral image of squares over 8-bit grey pixels in raster order. One
// pixel transaction is taken per clock unless the result side stalls, and each gives one result
// transaction carrying the sum and the sum of squares of all pixels above and to the left,
// inclusive, with tlast on the last pixel of the frame. The rate is set by the single line store,
// which holds the previous row's integral values and is read and written once per pixel; a write
// forwarded to a read of the same entry keeps narrow frames at full rate. The user must write
// width and height over csr only while the block is idle; the block does not check this. Zero
// acts as one, values beyond the maximum as the maximum. No clearing pass is needed after reset.
module integral_image_sum_and_square #(
   parameter int unsigned MAX_WIDTH  = iis_pkg::MAX_WIDTH_DEFAULT,
   parameter int unsigned MAX_HEIGHT = iis_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] pixel
   input  logic [iis_pkg::PIXEL_W-1:0]       req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [27:0] integral_sum, [63:28] integral_sq_sum
   output logic [iis_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [iis_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [iis_pkg::CFG_W-1:0]         csr_data
);
   import iis_pkg::*;

   localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   function automatic logic [31:0] dim_last(input logic [CFG_W-1:0] v,
                                            input int unsigned maxv);
      logic [31:0] c;
      c = 32'(v);
      if (c == 32'd0) begin
         c = 32'd1;
      end
      if (c > maxv) begin
         c = maxv;
      end
      return c - 32'd1;
   endfunction

   logic [CW-1:0]        width_last_ff,  width_last_in;
   logic [RW-1:0]        height_last_ff, height_last_in;
   logic [CW-1:0]        col_ff,         col_in;
   logic [RW-1:0]        row_ff,         row_in;
   logic [ROW_SUM_W-1:0] row_sum_ff,     row_sum_in;
   logic [ROW_SQ_W-1:0]  row_sq_ff,      row_sq_in;

   logic                 s1_valid_ff,    s1_valid_in;
   logic [CW-1:0]        s1_idx_ff;
   logic [ROW_SUM_W-1:0] s1_sum_ff;
   logic [ROW_SQ_W-1:0]  s1_sq_ff;
   logic                 s1_above_ff;
   logic                 s1_last_ff;

   logic                  out_valid_ff, out_valid_in;
   logic [OUT_SUM_W-1:0]  out_sum_ff;
   logic [OUT_SQ_W-1:0]   out_sq_ff;
   logic                  out_last_ff;

   logic                  accept;
   logic                  s1_adv;
   logic                  row_end;
   logic                  frame_end;
   logic [PIXEL_SQ_W-1:0] pixel_sq;
   logic [ROW_SUM_W-1:0]  row_sum_new;
   logic [ROW_SQ_W-1:0]   row_sq_new;
   line_entry_type        above;
   line_entry_type        rd_data;
   line_entry_type        wr_data;

   assign csr_ready = 1'b1;

   always_comb begin
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      if (csr_valid && (csr_index == REG_IMAGE_WIDTH)) begin
         width_last_in = CW'(dim_last(csr_data, MAX_WIDTH));
      end
      if (csr_valid && (csr_index == REG_IMAGE_HEIGHT)) begin
         height_last_in = RW'(dim_last(csr_data, MAX_HEIGHT));
      end
   end

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   assign row_end   = col_ff >= width_last_ff;
   assign frame_end = row_end && (row_ff >= height_last_ff);

   assign pixel_sq    = PIXEL_SQ_W'(req_tdata) * PIXEL_SQ_W'(req_tdata);
   assign row_sum_new = row_sum_ff + ROW_SUM_W'(req_tdata);
   assign row_sq_new  = row_sq_ff + ROW_SQ_W'(pixel_sq);

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      row_sum_in = row_sum_ff;
      row_sq_in  = row_sq_ff;
      if (accept) begin
         if (row_end) begin
            col_in     = '0;
            row_sum_in = '0;
            row_sq_in  = '0;
            row_in     = frame_end ? '0 : RW'(row_ff + 1'b1);
         end else begin
            col_in     = CW'(col_ff + 1'b1);
            row_sum_in = row_sum_new;
            row_sq_in  = row_sq_new;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      above          = s1_above_ff ? rd_data : '0;
      wr_data.sum    = LINE_SUM_W'(s1_sum_ff) + above.sum;
      wr_data.sq_sum = LINE_SQ_W'(s1_sq_ff) + above.sq_sum;
   end

   iis_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (s1_adv),
      .wr_addr (s1_idx_ff),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= CW'(dim_last(CFG_DIM_RESET, MAX_WIDTH));
         height_last_ff <= RW'(dim_last(CFG_DIM_RESET, MAX_HEIGHT));
         col_ff         <= '0;
         row_ff         <= '0;
         row_sum_ff     <= '0;
         row_sq_ff      <= '0;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         row_sum_ff     <= row_sum_in;
         row_sq_ff      <= row_sq_in;
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff   <= col_ff;
         s1_sum_ff   <= row_sum_new;
         s1_sq_ff    <= row_sq_new;
         s1_above_ff <= row_ff != '0;
         s1_last_ff  <= frame_end;
      end
      if (s1_adv) begin
         out_sum_ff  <= OUT_SUM_W'(wr_data.sum);
         out_sq_ff   <= OUT_SQ_W'(wr_data.sq_sum);
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_sq_ff, out_sum_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   a_accept_fills_stage : assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted pixel did not reach the second stage");

   a_adv_fills_output : assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> (rsp_tvalid && (rsp_tlast == $past(s1_last_ff))))
      else $error("second stage result did not reach the output register");

   a_col_in_range : assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < MAX_WIDTH) && (32'(row_ff) < MAX_HEIGHT))
      else $error("position counter beyond the line store");

   a_row_wrap : assert property (@(posedge clock) disable iff (reset)
      (accept && row_end && !frame_end) |=> ((col_ff == '0) && (row_ff != '0)))
      else $error("row end did not advance the row counter");

   a_frame_wrap : assert property (@(posedge clock) disable iff (reset)
      (accept && frame_end) |=> ((col_ff == '0) && (row_ff == '0)))
      else $error("frame end did not clear the position counters");
`endif

endmodule

// ----- rtl/iis_line_store.sv -----
module iis_line_store #(
   parameter int unsigned DEPTH = iis_pkg::MAX_WIDTH_DEFAULT,
   parameter int unsigned AW    = 10
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  iis_pkg::line_entry_type  wr_data,
   output iis_pkg::line_entry_type  rd_data
);
   import iis_pkg::*;

   line_entry_type mem [DEPTH];
   line_entry_type rd_data_ff;

   // A read that meets a write to the same entry returns the new value.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/integral_image_sum_and_square_tb.sv -----
`timescale 1ns / 1ps

module integral_image_sum_and_square_tb;
   import iis_pkg::*;

   localparam int MAX_W = MAX_WIDTH_DEFAULT;
   localparam int MAX_H = MAX_HEIGHT_DEFAULT;
   localparam int DIRECTED_STEPS = 25;
   localparam int RANDOM_PIXELS = 300;
   localparam int TALL_PIXELS = 64;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED = 8'd5;

   typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_type;

   typedef struct packed {
      logic [OUT_SUM_W-1:0] integral_sum;
      logic [OUT_SQ_W-1:0]  integral_sq_sum;
      logic                 frame_last;
   } integral_result_type;

   typedef struct packed {
      step_kind_type          kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CFG_W-1:0]       value;
      logic                   typed;
      logic [OUT_SUM_W-1:0]   integral_sum;
      logic [OUT_SQ_W-1:0]    integral_sq_sum;
      logic                   frame_last;
   } stim_step_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_data = '0;

   logic [CFG_W-1:0]      cfg_width = CFG_DIM_RESET;
   logic [CFG_W-1:0]      cfg_height = CFG_DIM_RESET;
   logic [ROW_SUM_W-1:0]  row_sum = '0;
   logic [ROW_SQ_W-1:0]   row_sq = '0;
   logic [LINE_SUM_W-1:0] line_sum [MAX_W];
   logic [LINE_SQ_W-1:0]  line_sq [MAX_W];
   logic [9:0]            col_pos = '0;
   logic [9:0]            row_pos = '0;

   integral_result_type pending_integrals [$];
   integral_result_type oldest;
   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  random_pixels = 0;
   int                  req_run = 0;
   int                  rsp_run = 0;
   logic                long_hold_armed = 1'b0;
   logic                long_hold_done = 1'b0;

   stim_step_type directed_steps [DIRECTED_STEPS] = '{
      '{STEP_PIXEL, '0, 11'd255, 1'b1, 28'd255, 36'd65025, 1'b0},
      '{STEP_PIXEL, '0, 11'd0, 1'b1, 28'd255, 36'd65025, 1'b0},
      '{STEP_PIXEL, '0, 11'd1, 1'b1, 28'd256, 36'd65026, 1'b0},
      '{STEP_WRITE, REG_IMAGE_WIDTH, 11'd0, 1'b0, '0, '0, 1'b0},
      '{STEP_WRITE, REG_IMAGE_HEIGHT, 11'd0, 1'b0, '0, '0, 1'b0},
      '{STEP_PIXEL, '0, 11'd7, 1'b1, 28'd263, 36'd65075, 1'b1},
      '{STEP_PIXEL, '0, 11'd255, 1'b1, 28'd255, 36'd65025, 1'b1},
      '{STEP_PIXEL, '0, 11'd0, 1'b1, 28'd0, 36'd0, 1'b1},
      '{STEP_WRITE, REG_IMAGE_WIDTH, 11'd2, 1'b0, '0, '0, 1'b0},
      '{STEP_WRITE, REG_IMAGE_HEIGHT, 11'd3, 1'b0, '0, '0, 1'b0},
      '{STEP_PIXEL, '0, 11'd255, 1'b0, '0, '0, 1'b0},
      '{STEP_PIXEL, '0, 11'd255, 1'b0, '0, '0, 1'b0},
      '{STEP_PIXEL, '0, 11'd0, 1'b0, '0, '0, 1'b0},
      '{STEP_PIXEL, '0, 11'd255, 1'b0, '0, '0, 1'b0},
      '{STEP_WRITE, REG_IMAGE_WIDTH, 11'd1, 1'b0, '0, '0, 1'b0},
      '{STEP_PIXEL, '0, 11'd128, 1'b0, '0, '0, 1'b0},
      '{STEP_WRITE, REG_UNMAPPED, 11'd5, 1'b0, '0, '0, 1'b0},
      '{STEP_WRITE, REG_IMAGE_HEIGHT, 11'd2047, 1'b0, '0, '0, 1'b0},
      '{STEP_WRITE, REG_IMAGE_WIDTH, 11'd1025, 1'b0, '0, '0, 1'b0},
      '{STEP_PIXEL, '0, 11'd255, 1'b1, 28'd255, 36'd65025, 1'b0},
      '{STEP_PIXEL, '0, 11'd255, 1'b0, '0, '0, 1'b0},
      '{STEP_WRITE, REG_IMAGE_HEIGHT, 11'd1, 1'b0, '0, '0, 1'b0},
      '{STEP_WRITE, REG_IMAGE_WIDTH, 11'd3, 1'b0, '0, '0, 1'b0},
      '{STEP_PIXEL, '0, 11'd0, 1'b0, '0, '0, 1'b0},
      '{STEP_PIXEL, '0, 11'd255, 1'b0, '0, '0, 1'b0}
   };

   integral_image_sum_and_square uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int unsigned active_dim(input logic [CFG_W-1:0] value,
                                              input int unsigned top);
      if (value == 0) return 1;
      if (value > top) return top;
      return 32'(value);
   endfunction

   function automatic integral_result_type predict_integral(input logic [PIXEL_W-1:0] px);
      int unsigned           w;
      int unsigned           h;
      logic                  row_end;
      logic                  frame_end;
      logic [LINE_SUM_W-1:0] isum;
      logic [LINE_SQ_W-1:0]  isq;
      integral_result_type   r;
      w = active_dim(cfg_width, MAX_W);
      h = active_dim(cfg_height, MAX_H);
      row_end = col_pos >= w - 1;
      frame_end = row_end && (row_pos >= h - 1);
      row_sum = row_sum + ROW_SUM_W'(px);
      row_sq = row_sq + ROW_SQ_W'(px) * ROW_SQ_W'(px);
      isum = LINE_SUM_W'(row_sum);
      isq = LINE_SQ_W'(row_sq);
      if (row_pos != 0) begin
         isum = isum + line_sum[col_pos];
         isq = isq + line_sq[col_pos];
      end
      line_sum[col_pos] = isum;
      line_sq[col_pos] = isq;
      r.integral_sum = isum[OUT_SUM_W-1:0];
      r.integral_sq_sum = isq[OUT_SQ_W-1:0];
      r.frame_last = frame_end;
      if (row_end) begin
         col_pos = '0;
         row_sum = '0;
         row_sq = '0;
         row_pos = frame_end ? '0 : row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
      return r;
   endfunction

   // Mostly a random idle wait, with occasional runs at full rate.
   function automatic int draw_wait(inout int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) run_left = $urandom_range(8, 40);
      return $urandom_range(0, 9);
   endfunction

   function automatic logic [PIXEL_W-1:0] draw_pixel();
      if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      return PIXEL_W'($urandom_range(0, 255));
   endfunction

   task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic typed,
                             input integral_result_type typed_result);
      int                  gap;
      integral_result_type predicted;
      gap = draw_wait(req_run);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_integral(px);
      pending_integrals.push_back(typed ? typed_result : predicted);
   endtask

   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_integrals.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CFG_W-1:0] value);
      settle_block();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == REG_IMAGE_WIDTH) cfg_width = value;
      else if (index == REG_IMAGE_HEIGHT) cfg_height = value;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_integrals.size() == 0) begin
            $error("result transaction with no pixel pending");
            error_count++;
         end else begin
            oldest = pending_integrals.pop_front();
            if (rsp_tdata[OUT_SUM_W-1:0] !== oldest.integral_sum) begin
               $error("integral_sum: expected %0d, got %0d", oldest.integral_sum,
                      rsp_tdata[OUT_SUM_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[OUT_SUM_W +: OUT_SQ_W] !== oldest.integral_sq_sum) begin
               $error("integral_sq_sum: expected %0d, got %0d", oldest.integral_sq_sum,
                      rsp_tdata[OUT_SUM_W +: OUT_SQ_W]);
               error_count++;
            end
            if (rsp_tlast !== oldest.frame_last) begin
               $error("frame_last: expected %0d, got %0d", oldest.frame_last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin : result_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(rsp_run);
         if (long_hold_armed && !long_hold_done) begin
            stall = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : pixel_source
      int unsigned   seg_len;
      stim_step_type step;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_STEPS; i++) begin
         step = directed_steps[i];
         if (step.kind == STEP_WRITE) begin
            write_reg(step.index, step.value);
         end else begin
            send_pixel(step.value[PIXEL_W-1:0], step.typed,
                       '{step.integral_sum, step.integral_sq_sum, step.frame_last});
         end
      end

      // One full row at the widest size, every pixel at full scale, so that every
      // line-store entry is written before any width change in the middle of a frame.
      write_reg(REG_IMAGE_WIDTH, 11'd1024);
      write_reg(REG_IMAGE_HEIGHT, 11'd2);
      while (row_pos == 0) send_pixel(8'hFF, 1'b0, '0);
      repeat (4) send_pixel(draw_pixel(), 1'b0, '0);
      write_reg(REG_IMAGE_WIDTH, 11'd1);
      send_pixel(draw_pixel(), 1'b0, '0);

      // The start of a single-column frame of the tallest size, with the result side
      // held off for a long stretch so that the input stalls.
      write_reg(REG_IMAGE_HEIGHT, 11'd1024);
      long_hold_armed = 1'b1;
      repeat (TALL_PIXELS) send_pixel(draw_pixel(), 1'b0, '0);

      while (random_pixels < RANDOM_PIXELS) begin
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 19))
               0: write_reg(REG_IMAGE_WIDTH, 11'd0);
               1: write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(1025, 2047)));
               2: write_reg(REG_IMAGE_WIDTH, 11'd1024);
               3: write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(17, 1023)));
               default: write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(1, 16)));
            endcase
         end
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 19))
               0: write_reg(REG_IMAGE_HEIGHT, 11'd0);
               1: write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(1025, 2047)));
               2: write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(9, 1024)));
               default: write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(1, 8)));
            endcase
         end
         seg_len = $urandom_range(1, 48);
         repeat (seg_len) begin
            send_pixel(draw_pixel(), 1'b0, '0);
            random_pixels++;
         end
         if ($urandom_range(0, 3) == 0) settle_block();
      end

      settle_block();
      repeat (8) @(posedge clock);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
